/* rtl/core/npim_pkg.sv */
// npim_pkg: shared types, constants and codes for the nearest palette index mapper.
// Used by npim_dist, the top level, npim_checker and the bench; depends on nothing.
`default_nettype none

package npim_pkg;

  localparam int unsigned PALETTE_DEPTH_DEF = 256;

  localparam int unsigned CH_W    = 8;           // one color channel
  localparam int unsigned RGB_W   = 3 * CH_W;    // packed palette entry
  localparam int unsigned IDX_W   = 8;           // palette index on the result port
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned SQ_W    = 2 * CH_W;
  localparam int unsigned DIST_W  = SQ_W + 2;    // sum of three squares
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  localparam logic [COUNT_W-1:0] COUNT_RESET       = 9'd256;
  localparam logic [CH_W-1:0]    ALPHA_THRESHOLD   = 8'd128;
  localparam logic [IDX_W-1:0]   TRANSPARENT_INDEX = 8'd255;

  // commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_MAP  = 1'b1;

  // texture modes (code 3 behaves as normal search)
  localparam logic [MODE_W-1:0] MODE_NORMAL      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ALPHA_TEST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_INDEX_ALPHA = 2'd2;

  // register select, taken from paddr[2]
  localparam logic REG_COUNT = 1'b0;
  localparam logic REG_MODE  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DRAIN
  } state_t;

  // travels alongside each palette entry through the distance unit
  typedef struct packed {
    logic             vld;
    logic             last;
    logic [IDX_W-1:0] idx;
  } entry_tag_t;

endpackage

`default_nettype wire

/* rtl/core/npim_ram.sv */
// npim_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing; holds the palette.
`default_nettype none

module npim_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* rtl/core/npim_dist.sv */
// npim_dist: shared squared-distance and running-minimum unit, one entry per cycle.
// Depends on npim_pkg. Squares are registered, then the sum, then the compare.
`default_nettype none

module npim_dist (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          clr,
  input  wire logic [npim_pkg::RGB_W-1:0]    pixel,
  input  wire logic [npim_pkg::RGB_W-1:0]    entry,
  input  wire npim_pkg::entry_tag_t          tag,
  output logic                               res_vld,
  output logic      [npim_pkg::IDX_W-1:0]    res_idx
);

  import npim_pkg::*;

  logic [SQ_W-1:0]   sq_r [3];
  logic [SQ_W-1:0]   sq_nxt [3];
  entry_tag_t        tag1_r;
  entry_tag_t        tag2_r;
  logic [DIST_W-1:0] dist_r;
  logic [DIST_W-1:0] min_dist_r;
  logic [DIST_W-1:0] min_dist_nxt;
  logic [IDX_W-1:0]  best_idx_r;
  logic [IDX_W-1:0]  best_idx_nxt;
  logic              better;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [CH_W-1:0] a;
      logic [CH_W-1:0] b;
      logic [CH_W-1:0] d;
      a = pixel[c*CH_W +: CH_W];
      b = entry[c*CH_W +: CH_W];
      d = (a > b) ? (a - b) : (b - a);
      sq_nxt[c] = SQ_W'(d) * SQ_W'(d);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
    end else begin
      tag1_r <= tag;
      tag2_r <= tag1_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      sq_r[c] <= sq_nxt[c];
    end
    dist_r <= DIST_W'(sq_r[0]) + DIST_W'(sq_r[1]) + DIST_W'(sq_r[2]);
  end

  // strict less-than keeps the lowest index on a tie
  assign better = (dist_r < min_dist_r);

  always_comb begin
    min_dist_nxt = min_dist_r;
    best_idx_nxt = best_idx_r;
    if (clr) begin
      min_dist_nxt = '1;
      best_idx_nxt = '0;
    end else if (tag2_r.vld && better) begin
      min_dist_nxt = dist_r;
      best_idx_nxt = tag2_r.idx;
    end
  end

  always_ff @(posedge clk) begin
    min_dist_r <= min_dist_nxt;
    best_idx_r <= best_idx_nxt;
  end

  assign res_vld = tag2_r.vld && tag2_r.last;
  assign res_idx = better ? tag2_r.idx : best_idx_r;

endmodule

`default_nettype wire

/* rtl/core/nearest_palette_index_mapper.sv */
// nearest_palette_index_mapper: top level; palette RAM, search sequencer, APB registers.
// Depends on npim_pkg, npim_ram and npim_dist.
//
//   channel   direction  handshake                 payload
//   input     in         start & !busy             in_command, in_entry_index, in_red,
//                                                  in_green, in_blue, in_alpha
//   result    out        out_valid (one cycle)     out_color_index
//   config    in/out     psel & penable & pwrite   paddr, pwdata -> prdata
//
// A load is written on its accept edge and leaves busy low. A map that needs no search
// (index-alpha, alpha-test transparent, zero count) shows its result in the next cycle.
// A search holds busy while the palette RAM is read one entry per cycle and the last entry
// drains through squares, sum and compare in npim_dist; the result shows as busy drops.
// Reset is synchronous and needs no clearing pass; the receiver cannot stall results.
`default_nettype none

module nearest_palette_index_mapper #(
  parameter int unsigned PALETTE_DEPTH = npim_pkg::PALETTE_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           in_command,
  input  wire logic [npim_pkg::IDX_W-1:0]     in_entry_index,
  input  wire logic [npim_pkg::CH_W-1:0]      in_red,
  input  wire logic [npim_pkg::CH_W-1:0]      in_green,
  input  wire logic [npim_pkg::CH_W-1:0]      in_blue,
  input  wire logic [npim_pkg::CH_W-1:0]      in_alpha,
  output logic                                out_valid,
  output logic      [npim_pkg::IDX_W-1:0]     out_color_index,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [npim_pkg::APB_AW-1:0]    paddr,
  input  wire logic [npim_pkg::APB_DW-1:0]    pwdata,
  output logic      [npim_pkg::APB_DW-1:0]    prdata,
  output logic                                pready
);

  import npim_pkg::*;

  localparam int unsigned AW = $clog2(PALETTE_DEPTH);
  localparam logic [COUNT_W-1:0] DEPTH_CNT = COUNT_W'(PALETTE_DEPTH);

  // configuration registers
  logic [COUNT_W-1:0] palette_count_r;
  logic [MODE_W-1:0]  tex_mode_r;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      palette_count_r <= COUNT_RESET;
      tex_mode_r      <= MODE_NORMAL;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_COUNT: palette_count_r <= pwdata[COUNT_W-1:0];
        REG_MODE:  tex_mode_r      <= pwdata[MODE_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_COUNT: prdata = APB_DW'(palette_count_r);
      REG_MODE:  prdata = APB_DW'(tex_mode_r);
      default:   prdata = '0;
    endcase
  end

  // input decode
  logic               accept;
  logic               load_we;
  logic               map_acc;
  logic [COUNT_W-1:0] count_sat;
  logic               need_search;
  logic [IDX_W-1:0]   quick_idx;

  assign accept  = start && !busy;
  assign load_we = accept && (in_command == CMD_LOAD)
                   && ({1'b0, in_entry_index} < DEPTH_CNT);
  assign map_acc = accept && (in_command == CMD_MAP);

  assign count_sat = (palette_count_r > DEPTH_CNT) ? DEPTH_CNT : palette_count_r;

  always_comb begin
    need_search = 1'b0;
    quick_idx   = '0;
    if (tex_mode_r == MODE_INDEX_ALPHA) begin
      quick_idx = in_alpha;
    end else if ((tex_mode_r == MODE_ALPHA_TEST) && (in_alpha < ALPHA_THRESHOLD)) begin
      quick_idx = TRANSPARENT_INDEX;
    end else if (count_sat != '0) begin
      need_search = 1'b1;
    end
  end

  // search sequencer
  state_t          state_r;
  state_t          state_nxt;
  logic [AW-1:0]   rd_addr_r;
  logic [AW-1:0]   rd_addr_nxt;
  logic [AW-1:0]   last_addr_r;
  logic [RGB_W-1:0] pixel_r;
  logic            rd_en;
  logic            rd_last;
  logic            dist_res_vld;
  logic [IDX_W-1:0] dist_res_idx;

  assign rd_last = (rd_addr_r == last_addr_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (map_acc && need_search) state_nxt = ST_SEARCH;
      ST_SEARCH: if (rd_last) state_nxt = ST_DRAIN;
      ST_DRAIN:  if (dist_res_vld) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy  = 1'b1;
    rd_en = 1'b0;
    case (state_r)
      ST_IDLE:   busy  = 1'b0;
      ST_SEARCH: rd_en = 1'b1;
      ST_DRAIN:  ;
      default:   busy  = 1'b1;
    endcase
  end

  assign rd_addr_nxt = (state_r == ST_SEARCH) ? (rd_addr_r + 1'b1) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r <= rd_addr_nxt;
    if (map_acc) begin
      pixel_r     <= {in_red, in_green, in_blue};
      last_addr_r <= AW'(count_sat - 1'b1);
    end
  end

  // palette RAM
  logic [RGB_W-1:0] entry_data;
  entry_tag_t       rd_tag_r;

  npim_ram #(
    .WIDTH (RGB_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (in_entry_index[AW-1:0]),
    .wdata ({in_red, in_green, in_blue}),
    .raddr (rd_addr_r),
    .rdata (entry_data)
  );

  // tag lines up with the registered read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_tag_r <= '0;
    end else begin
      rd_tag_r.vld  <= rd_en;
      rd_tag_r.last <= rd_en && rd_last;
      rd_tag_r.idx  <= IDX_W'(rd_addr_r);
    end
  end

  npim_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (map_acc),
    .pixel   (pixel_r),
    .entry   (entry_data),
    .tag     (rd_tag_r),
    .res_vld (dist_res_vld),
    .res_idx (dist_res_idx)
  );

  // result register
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [IDX_W-1:0] out_idx_r;
  logic [IDX_W-1:0] out_idx_nxt;

  always_comb begin
    out_valid_nxt = 1'b0;
    out_idx_nxt   = out_idx_r;
    if (dist_res_vld) begin
      out_valid_nxt = 1'b1;
      out_idx_nxt   = dist_res_idx;
    end else if (map_acc && !need_search) begin
      out_valid_nxt = 1'b1;
      out_idx_nxt   = quick_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_idx_r <= out_idx_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_color_index = out_idx_r;

endmodule

`default_nettype wire

/* rtl/core/npim_checker.sv */
// npim_checker: port-level assertions for nearest_palette_index_mapper, bound to the top.
// Depends on npim_pkg and the top level's port list.
`default_nettype none

module npim_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           start,
  input wire logic                           busy,
  input wire logic                           in_command,
  input wire logic                           out_valid,
  input wire logic                           pready
);

  import npim_pkg::*;

  // leaving reset the block is ready for an item
  a_idle_after_reset: assert property (@(posedge clk)
    $rose(rst_n) |-> !busy)
    else $error("busy high right after reset");

  // a load never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_command == CMD_LOAD) |=> !out_valid)
    else $error("result after a load item");

  // a map either starts a search or answers at once
  a_map_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_command == CMD_MAP) |=> (busy || out_valid))
    else $error("map item neither searched nor answered");

  // a search ends with its result in the cycle busy drops
  a_search_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("search ended without a result");

  // a result without a prior search comes from an item accepted the cycle before
  a_no_stray: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(busy) |-> $past(start) && pready)
    else $error("result with no item behind it");

endmodule

bind nearest_palette_index_mapper npim_checker u_npim_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_command (in_command),
  .out_valid  (out_valid),
  .pready     (pready)
);

`default_nettype wire

/* tb/nearest_palette_index_mapper_test.sv */
// nearest_palette_index_mapper_test: self-checking bench for the palette index mapper.
// Uses npim_pkg for widths and codes; drives loads, maps and APB writes, and predicts
// every color index with a tracked copy of the palette and registers.
`default_nettype none

module nearest_palette_index_mapper_test;
  timeunit 1ns;
  timeprecision 1ps;
  import npim_pkg::*;

  localparam int SETTLE_CYCLES = PALETTE_DEPTH_DEF + 8;
  localparam int REPORT_LIMIT  = 10;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  class color_index_tracker;
    bit [RGB_W-1:0]   palette [PALETTE_DEPTH_DEF];
    bit [COUNT_W-1:0] count;
    bit [MODE_W-1:0]  mode;
    bit [IDX_W-1:0]   pending_idx [$];
    int               errors;

    function new();
      foreach (palette[i]) palette[i] = '0;
      count  = COUNT_RESET;
      mode   = MODE_NORMAL;
      errors = 0;
    endfunction

    function void write_reg(logic sel, logic [APB_DW-1:0] value);
      if (sel == REG_COUNT) begin
        count = value[COUNT_W-1:0];
      end else begin
        mode = value[MODE_W-1:0];
      end
    endfunction

    function void add_expected(bit [IDX_W-1:0] v);
      pending_idx = {pending_idx, v};
    endfunction

    // least squared RGB distance, lowest index on a tie
    function bit [IDX_W-1:0] nearest_index(bit [CH_W-1:0] r, bit [CH_W-1:0] g,
                                           bit [CH_W-1:0] b);
      int limit, best, best_sq, sum_sq, dr, dg, db;
      limit   = (count > PALETTE_DEPTH_DEF) ? PALETTE_DEPTH_DEF : int'(count);
      best    = 0;
      best_sq = 1 << 30;
      for (int i = 0; i < limit; i++) begin
        dr     = int'(r) - int'(palette[i][RGB_W-1 -: CH_W]);
        dg     = int'(g) - int'(palette[i][2*CH_W-1 -: CH_W]);
        db     = int'(b) - int'(palette[i][CH_W-1:0]);
        sum_sq = dr * dr + dg * dg + db * db;
        if (sum_sq < best_sq) begin
          best_sq = sum_sq;
          best    = i;
        end
      end
      return best[IDX_W-1:0];
    endfunction

    function void note_item(logic cmd, logic [IDX_W-1:0] slot, logic [CH_W-1:0] r,
                            logic [CH_W-1:0] g, logic [CH_W-1:0] b, logic [CH_W-1:0] a);
      if (cmd == CMD_LOAD) begin
        if (slot < PALETTE_DEPTH_DEF) palette[slot] = {r, g, b};
      end else if (mode == MODE_ALPHA_TEST && a < ALPHA_THRESHOLD) begin
        add_expected(TRANSPARENT_INDEX);
      end else if (mode == MODE_INDEX_ALPHA) begin
        add_expected(a);
      end else begin
        add_expected(nearest_index(r, g, b));
      end
    endfunction

    function void check_result(logic [IDX_W-1:0] got);
      bit [IDX_W-1:0] want;
      if (pending_idx.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT) $display("unexpected color index %0d", got);
      end else begin
        want = pending_idx.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("color index mismatch: expected %0d, got %0d", want, got);
        end
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n          = 1'b0;
  logic               start          = 1'b0;
  logic               busy;
  logic               in_command     = CMD_LOAD;
  logic [IDX_W-1:0]   in_entry_index = '0;
  logic [CH_W-1:0]    in_red         = '0;
  logic [CH_W-1:0]    in_green       = '0;
  logic [CH_W-1:0]    in_blue        = '0;
  logic [CH_W-1:0]    in_alpha       = '0;
  logic               out_valid;
  logic [IDX_W-1:0]   out_color_index;
  logic               psel           = 1'b0;
  logic               penable        = 1'b0;
  logic               pwrite         = 1'b0;
  logic [APB_AW-1:0]  paddr          = '0;
  logic [APB_DW-1:0]  pwdata         = '0;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  color_index_tracker tracker = new();
  int idle_pct = 0;
  int filled   = 0;   // entries 0..filled-1 have been loaded

  nearest_palette_index_mapper u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_entry_index (in_entry_index),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_alpha       (in_alpha),
    .out_valid      (out_valid),
    .out_color_index(out_color_index),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result first: it belongs to an item accepted on an earlier edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) tracker.check_result(out_color_index);
      if (start && !busy)
        tracker.note_item(in_command, in_entry_index, in_red, in_green, in_blue, in_alpha);
    end
  end

  // an idle edge after the access phase keeps writes apart
  task automatic apb_write(logic sel, logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.write_reg(sel, value);
    @(posedge clk);
  endtask

  task automatic send(logic cmd, logic [IDX_W-1:0] slot, logic [CH_W-1:0] r,
                      logic [CH_W-1:0] g, logic [CH_W-1:0] b, logic [CH_W-1:0] a);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    start          <= 1'b1;
    in_command     <= cmd;
    in_entry_index <= slot;
    in_red         <= r;
    in_green       <= g;
    in_blue        <= b;
    in_alpha       <= a;
    do @(posedge clk); while (busy);
  endtask

  // wait out every outstanding map, plus a full search, before touching registers
  task automatic settle();
    start <= 1'b0;
    while (tracker.pending_idx.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CH_W-1:0] nudge(logic [CH_W-1:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 4)) - 2;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[CH_W-1:0];
  endfunction

  task automatic random_item(int eff);
    logic [RGB_W-1:0] color;
    logic [CH_W-1:0]  a;
    color = RGB_W'($urandom());
    a     = CH_W'(($urandom_range(0, 3) == 0) ? $urandom_range(126, 129)
                                              : $urandom_range(0, 255));
    if ($urandom_range(0, 99) < 30) begin
      // some loads duplicate an entry in use, to set up ties
      if (eff > 0 && $urandom_range(0, 3) == 0) color = tracker.palette[$urandom_range(0, eff-1)];
      send(CMD_LOAD, IDX_W'($urandom_range(0, 255)), color[23:16], color[15:8], color[7:0], a);
    end else begin
      if (eff > 0 && $urandom_range(0, 1) == 0) begin
        color = tracker.palette[$urandom_range(0, eff-1)];
        color = {nudge(color[23:16]), nudge(color[15:8]), nudge(color[7:0])};
      end
      send(CMD_MAP, IDX_W'($urandom_range(0, 255)), color[23:16], color[15:8], color[7:0], a);
    end
  endtask

  task automatic run_phase(int count, logic [MODE_W-1:0] mode, int idle, int n);
    logic [RGB_W-1:0] color;
    int eff;
    settle();
    apb_write(REG_COUNT, count);
    apb_write(REG_MODE, APB_DW'(mode));
    idle_pct = idle;
    eff = (count > PALETTE_DEPTH_DEF) ? PALETTE_DEPTH_DEF : count;
    // every searched entry must hold a loaded color
    while (filled < eff) begin
      color = RGB_W'($urandom());
      send(CMD_LOAD, IDX_W'(filled), color[23:16], color[15:8], color[7:0],
           CH_W'($urandom_range(0, 255)));
      filled++;
    end
    repeat (n) random_item(eff);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    apb_write(REG_COUNT, 4);
    apb_write(REG_MODE, APB_DW'(MODE_NORMAL));
    send(CMD_LOAD, 0, 8'h00, 8'h00, 8'h00, 8'h00);
    send(CMD_LOAD, 1, 8'hff, 8'hff, 8'hff, 8'hff);
    send(CMD_LOAD, 2, 8'hff, 8'h00, 8'h00, 8'h00);
    send(CMD_LOAD, 3, 8'hff, 8'h00, 8'h00, 8'hff);  // same color as entry 2
    filled = 4;
    send(CMD_MAP, 0, 8'h00, 8'h00, 8'h00, 8'hff);
    send(CMD_MAP, 255, 8'hff, 8'hff, 8'hff, 8'h00);
    send(CMD_MAP, 0, 8'hfe, 8'h01, 8'h01, 8'h00);   // tie between entries 2 and 3
    send(CMD_MAP, 0, 8'h7f, 8'h7f, 8'h7f, 8'h80);
    send(CMD_MAP, 0, 8'h80, 8'h80, 8'h80, 8'h7f);
    send(CMD_LOAD, 255, 8'h12, 8'h34, 8'h56, 8'h00);

    settle();
    apb_write(REG_MODE, APB_DW'(MODE_ALPHA_TEST));
    send(CMD_MAP, 0, 8'hff, 8'hff, 8'hff, 8'h7f);
    send(CMD_MAP, 0, 8'hff, 8'hff, 8'hff, 8'h80);
    send(CMD_MAP, 0, 8'h00, 8'h00, 8'h00, 8'h00);
    send(CMD_MAP, 0, 8'hff, 8'h00, 8'h00, 8'hff);

    settle();
    apb_write(REG_MODE, APB_DW'(MODE_INDEX_ALPHA));
    send(CMD_MAP, 0, 8'h00, 8'h00, 8'h00, 8'h00);
    send(CMD_MAP, 0, 8'hff, 8'hff, 8'hff, 8'hff);
    send(CMD_MAP, 0, 8'h10, 8'h20, 8'h30, 8'h5a);

    settle();
    apb_write(REG_MODE, APB_DW'(MODE_UNUSED));
    send(CMD_MAP, 0, 8'h01, 8'h02, 8'h03, 8'h00);

    settle();
    apb_write(REG_COUNT, 0);
    apb_write(REG_MODE, APB_DW'(MODE_NORMAL));
    send(CMD_MAP, 0, 8'hff, 8'hff, 8'hff, 8'hff);

    run_phase(16,  MODE_NORMAL,      0,  140);
    run_phase(3,   MODE_ALPHA_TEST,  75, 150);
    run_phase(1,   MODE_NORMAL,      29, 100);
    run_phase(64,  MODE_UNUSED,      0,  150);
    run_phase(7,   MODE_INDEX_ALPHA, 75, 100);
    run_phase(256, MODE_ALPHA_TEST,  29, 80);
    run_phase(0,   MODE_NORMAL,      0,  100);
    run_phase(511, MODE_UNUSED,      75, 40);   // saturates to the full palette
    run_phase(2,   MODE_ALPHA_TEST,  0,  120);
    run_phase(32,  MODE_NORMAL,      29, 200);
    run_phase(255, MODE_NORMAL,      75, 40);
    run_phase(5,   MODE_UNUSED,      29, 100);

    settle();
    if (tracker.errors == 0 && tracker.pending_idx.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
